// ===== src/itrs_pkg.sv =====
// ----------------------------------------------------------------------------
// itrs_pkg: shared constants for the integer to radix string converter
// Character codes, radix limits and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package itrs_pkg;

  // Radix register
  localparam int unsigned RadixW = 6;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;

  // Output characters
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] CharZero   = 7'h30;
  localparam logic [CharW-1:0] CharLowerA = 7'h61;
  localparam logic [CharW-1:0] CharMinus  = 7'h2D;
  localparam logic [RadixW-1:0] DecimalLimit = 6'd10;

  typedef logic [RadixW-1:0] digit_t;
  typedef logic [CharW-1:0]  char_t;

  // Map a digit value 0..35 to '0'..'9' or 'a'..'z'
  function automatic char_t digit_char(digit_t d);
    char_t c;
    if (d >= DecimalLimit) begin
      c = CharLowerA + char_t'(d - DecimalLimit);
    end else begin
      c = CharZero + char_t'(d);
    end
    return c;
  endfunction

endpackage

// ===== src/integer_to_radix_string.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_string: signed integer to ASCII text in radix 2..36
// Converts one signed integer per input beat into a run of characters,
// most significant first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Payload                                   Beat when
//  cfg         in         cfg_data_i: radix (6 bits)                cfg_valid_i & cfg_ready_o
//  s_axis      in         tdata: value (VALUE_BITS, byte padded)    tvalid & tready
//  m_axis      out        tdata: character (7 bits), tlast: last    tvalid & tready
//
//  A one-bit restoring divider is shared by all digits, and each character
//  then passes through the registered read of the digit store before it
//  reaches the output register.
//  s_axis_tready is high only while the sequencer is idle; the final
//  character may still wait in the output register when the next value is taken.
//  A stalled output register holds the sequencer in its emit steps.
//  Reset clears the sequencer and the output valid and sets radix to 10.
//
module integer_to_radix_string import itrs_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write: radix
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [RadixW-1:0]                     cfg_data_i,
  // input stream, tdata: value [VALUE_BITS-1:0], zero padded to bytes
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // output stream, tdata: character [6:0], zero bit [7]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [7:0]                            m_axis_tdata,
  output logic                                  m_axis_tlast
);

  localparam int unsigned CntW = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [RadixW-1:0]     radix_q;
  logic [RadixW-1:0]     base_q, base_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  digit_t                rem_q, rem_d;
  logic [CntW-1:0]       bcnt_q, bcnt_d;
  logic [CntW-1:0]       dcnt_q, dcnt_d;
  logic                  m_valid_q, m_valid_d;
  char_t                 m_char_q, m_char_d;
  logic                  m_last_q, m_last_d;

  digit_t                dig_mem [VALUE_BITS];
  digit_t                rd_q;
  logic                  mem_we;

  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RadixW-1:0]     base_clamp;
  logic [RadixW:0]       step_sh;
  logic [RadixW+1:0]     step_diff;
  logic                  step_bit;
  digit_t                step_rem;
  logic [VALUE_BITS-1:0] step_quo;
  logic                  out_free;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  // Clamp the radix into 2..36
  always_comb begin
    if (radix_q < RadixMin) begin
      base_clamp = RadixMin;
    end else if (radix_q > RadixMax) begin
      base_clamp = RadixMax;
    end else begin
      base_clamp = radix_q;
    end
  end

  // Take the magnitude of the incoming value
  assign in_val = s_axis_tdata[VALUE_BITS-1:0];
  assign in_mag = in_val[VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;

  // One restoring division step: shift in the next dividend bit, trial subtract
  assign step_sh   = {rem_q, quo_q[VALUE_BITS-1]};
  assign step_diff = {1'b0, step_sh} - {2'b00, base_q};
  assign step_bit  = ~step_diff[RadixW+1];
  assign step_rem  = step_bit ? step_diff[RadixW-1:0] : step_sh[RadixW-1:0];
  assign step_quo  = {quo_q[VALUE_BITS-2:0], step_bit};

  assign out_free      = ~m_valid_q | m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    neg_d     = neg_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bcnt_d    = bcnt_q;
    dcnt_d    = dcnt_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    mem_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          neg_d   = in_val[VALUE_BITS-1];
          quo_d   = in_mag;
          rem_d   = '0;
          bcnt_d  = CntW'(VALUE_BITS - 1);
          dcnt_d  = '0;
          base_d  = base_clamp;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        quo_d  = step_quo;
        rem_d  = step_rem;
        bcnt_d = bcnt_q - 1'b1;
        if (bcnt_q == '0) begin
          // store the digit, then stop or start the next division
          mem_we = 1'b1;
          if (step_quo == '0) begin
            state_d = S_SIGN;
          end else begin
            rem_d  = '0;
            bcnt_d = CntW'(VALUE_BITS - 1);
            dcnt_d = dcnt_q + 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (!neg_q) begin
          state_d = S_READ;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = CharMinus;
          m_last_d  = 1'b0;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = digit_char(rd_q);
          m_last_d  = (dcnt_q == '0);
          if (dcnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            dcnt_d  = dcnt_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    neg_q    <= neg_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    bcnt_q   <= bcnt_d;
    dcnt_q   <= dcnt_d;
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
  end

  // Digit store: write least significant digit first, read back in reverse
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[dcnt_q] <= step_rem;
    end
    if (state_q == S_READ) begin
      rd_q <= dig_mem[dcnt_q];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_char_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_to_radix_string
// Streams signed 32-bit values through the converter under a series of radix
// settings and checks every character and end-of-run flag against an
// independent digit predictor. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import itrs_pkg::*;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int          IDLE_PCT    = 32;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          SETTLE      = 8;
  localparam int          TAIL_CYCLES = 1200;
  localparam int          LIMIT       = 2_000_000;
  localparam int          ITEMS_EACH  = 19;
  localparam int          MAX_PRINTS  = 50;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_beat_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [RadixW-1:0]     cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VALUE_BITS-1:0] s_axis_tdata  = '0;   // value [31:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;         // character [6:0], zero [7]
  logic                  m_axis_tlast;

  // Radix as last written, values waiting to go in, characters still owed
  logic [RadixW-1:0]     radix_q = RadixReset;
  logic [VALUE_BITS-1:0] pending_values [$];
  text_beat_t            expected_chars [$];

  bit steady    = 1'b0;
  bit hold_arm  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int errors      = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int negatives   = 0;
  int chars_seen  = 0;
  int radix_writes = 0;

  integer_to_radix_string #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Clamp the register value to the base actually used
  function automatic int unsigned base_of(logic [RadixW-1:0] r);
    if (r < RadixMin) return RadixMin;
    if (r > RadixMax) return RadixMax;
    return r;
  endfunction

  // Work out the characters of one value and queue them, most significant first
  function automatic void predict_text(logic [VALUE_BITS-1:0] v, logic [RadixW-1:0] r);
    int unsigned           base;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            digits [VALUE_BITS];
    int                    nd;
    bit                    neg;
    text_beat_t            tb;
    base = base_of(r);
    neg  = v[VALUE_BITS-1];
    mag  = neg ? (~v + 1'b1) : v;
    nd   = 0;
    if (mag == 0) begin
      digits[0] = '0;
      nd = 1;
    end
    while (mag != 0) begin
      digits[nd] = 6'(mag % base);
      mag = mag / base;
      nd++;
    end
    if (neg) begin
      tb.ch   = CharMinus;
      tb.last = 1'b0;
      expected_chars.push_back(tb);
      negatives++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      tb.ch   = (digits[i] < DecimalLimit) ? CharZero + char_t'(digits[i])
                                           : CharLowerA + char_t'(digits[i] - DecimalLimit);
      tb.last = (i == 0);
      expected_chars.push_back(tb);
    end
  endfunction

  // Pick a random value: wide, small, extreme, or near a power of the base
  function automatic logic [VALUE_BITS-1:0] next_value(int unsigned base);
    logic [VALUE_BITS-1:0] v;
    logic [63:0]           p;
    int                    k;
    case ($urandom_range(5))
      1: begin
        v = $urandom_range(50);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0000;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      3: begin
        p = 64'd1;
        k = $urandom_range(1, 31);
        repeat (k) begin
          if (p * base <= 64'h7fff_ffff) p = p * base;
        end
        v = p[31:0] + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what);
    if (errors < MAX_PRINTS)
      $display("mismatch @cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // Compare one output beat with the oldest owed character
  task automatic check_char();
    text_beat_t want;
    chars_seen++;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast));
    end else begin
      want = expected_chars.pop_front();
      if (m_axis_tdata !== {1'b0, want.ch})
        report_mismatch($sformatf("tdata %h, want %h", m_axis_tdata, {1'b0, want.ch}));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
    end
  endtask

  // Input driver: predict on each accepted beat, then offer the next value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_text(s_axis_tdata, radix_q);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_values.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_values.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check accepted beats, stall at random or for one long hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_char();
      if (hold_arm && !hold_done && m_axis_tvalid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("[integer_to_radix_string] ERROR");
      $finish;
    end
  end

  // Wait until every value went in and every character came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_values.size() != 0 || s_axis_tvalid || expected_chars.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_radix(logic [RadixW-1:0] r);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    radix_q = r;
    radix_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus: directed corners per radix, then random phases
  initial begin
    logic [RadixW-1:0] phase_radix [10];
    phase_radix = '{6'd16, 6'd8, 6'd2, 6'd3, 6'd7, 6'd37, 6'd20, 6'd11, 6'd0, 6'd0};
    phase_radix[8] = $urandom_range(RadixMin, RadixMax);
    phase_radix[9] = $urandom_range(63);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset radix of ten: zero, one, minus one, both extremes, digit rollover
    pending_values = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                       32'd9, 32'd10, -32'sd10, 32'd1_000_000_000};
    wait_drained();

    // top radix: highest letter and both extremes
    write_radix(6'd36);
    pending_values = '{32'd35, 32'd36, 32'h7fff_ffff, 32'h8000_0000};
    wait_drained();

    // binary: longest runs, including the most negative value
    write_radix(6'd2);
    pending_values = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    wait_drained();

    // radix below range acts as binary
    write_radix(6'd0);
    pending_values = '{32'd5, -32'sd6};
    wait_drained();

    // radix above range acts as thirty-six; all register bits high
    write_radix(6'd63);
    pending_values = '{32'd1295, -32'sd46656};
    wait_drained();

    write_radix(6'd1);
    pending_values = '{32'd2};
    wait_drained();

    // random phases, one radix each
    for (int ph = 0; ph < 10; ph++) begin
      write_radix(phase_radix[ph]);
      @(negedge clk_i);
      steady   = (ph == 1);
      hold_arm = (ph == 4);
      repeat (ITEMS_EACH) pending_values.push_back(next_value(base_of(radix_q)));
      wait_drained();
      steady   = 1'b0;
      hold_arm = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d values (%0d negative), %0d characters, %0d radix writes",
             items_taken, negatives, chars_seen, radix_writes);
    $display("radix settings included both clamps, binary, thirty-six and a long output hold");
    if (errors == 0) begin
      $display("[integer_to_radix_string] OK");
    end else begin
      $display("[integer_to_radix_string] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/itrs_pkg.sv
src/integer_to_radix_string.sv
dv/testbench.sv
